### rtl/aslm_pkg.sv
// Shared types, constants and lookup functions for the autoranging sound level meter.
package aslm_pkg;

    // Sample and logarithm widths
    localparam int SAMPLE_BITS  = 12;
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int X_BITS       = SAMPLE_BITS + 1;
    localparam int N_BITS       = $clog2(X_BITS);
    localparam int FRAC_BITS    = 16;
    localparam int Y_BITS       = FRAC_BITS + 1;
    localparam int SH_BITS      = $clog2(FRAC_BITS + 1);
    localparam int L2_BITS      = N_BITS + FRAC_BITS;
    localparam int K_BITS       = 15;
    localparam int PROD_BITS    = L2_BITS + K_BITS + 1;
    localparam int LG_BITS      = 16;
    localparam int OFS_BITS     = 16;
    localparam int T_BITS       = LG_BITS + 2;
    localparam int SLOPE_BITS   = 7;
    localparam int V_BITS       = T_BITS + SLOPE_BITS;
    localparam int LVL_BITS     = 16;
    localparam int SUM_BITS     = V_BITS - 3;

    // log10(2) in Q0.16 and rounding point for Q.32 -> Q4.12
    localparam logic [K_BITS-1:0]    LOG10_2_Q16 = K_BITS'(19728);
    localparam logic [PROD_BITS-1:0] LG_RND      = PROD_BITS'(1) << 19;
    localparam int                   LG_SHIFT    = 20;

    // Pipeline: normalize, one stage per fraction bit, log10, slope, output
    localparam int SQ_STAGES = FRAC_BITS;
    localparam int DEPTH     = SQ_STAGES + 4;
    localparam int LAST      = DEPTH - 1;

    // Offset register reset (log10 of supply over full scale, Q4.12)
    localparam logic signed [OFS_BITS-1:0] LOG_OFS_RST = -16'sd12672;

    // Gain range codes
    localparam logic [1:0] RNG_HI  = 2'd0;
    localparam logic [1:0] RNG_MID = 2'd1;
    localparam logic [1:0] RNG_LO  = 2'd2;

    // Range windows
    localparam logic [SAMPLE_BITS-1:0] R0_HI = SAMPLE_BITS'(757);
    localparam logic [SAMPLE_BITS-1:0] R1_LO = SAMPLE_BITS'(6);
    localparam logic [SAMPLE_BITS-1:0] R1_HI = SAMPLE_BITS'(645);
    localparam logic [SAMPLE_BITS-1:0] R2_LO = SAMPLE_BITS'(13);
    localparam logic [SAMPLE_BITS-1:0] R2_HI = SAMPLE_BITS'(1203);

    typedef enum logic [1:0] {
        CRV_R0,
        CRV_R1,
        CRV_R2,
        CRV_OVL
    } t_curve;

    // Per-request sideband that rides beside the log pipeline
    typedef struct packed {
        logic       rd;
        logic       ovl;
        logic       chg;
        logic [1:0] rng;
        t_curve     curve;
    } t_side;

    // Log2 work word: mantissa, fraction bits so far, leading-one index
    typedef struct packed {
        logic [Y_BITS-1:0]    y;
        logic [FRAC_BITS-1:0] frac;
        logic [N_BITS-1:0]    n;
    } t_lgw;

    function automatic logic signed [SLOPE_BITS-1:0] curve_slope(input t_curve c);
        logic signed [SLOPE_BITS-1:0] s;
        unique case (c)
            CRV_R0:  s = SLOPE_BITS'(9);
            CRV_R1:  s = SLOPE_BITS'(12);
            CRV_R2:  s = SLOPE_BITS'(11);
            CRV_OVL: s = SLOPE_BITS'(45);
            default: s = SLOPE_BITS'(9);
        endcase
        return s;
    endfunction

    // Range offset already scaled to Q8.8
    function automatic logic signed [LVL_BITS-1:0] curve_base(input t_curve c);
        logic signed [LVL_BITS-1:0] b;
        unique case (c)
            CRV_R0:  b = 16'sd10240;
            CRV_R1:  b = 16'sd14848;
            CRV_R2:  b = 16'sd19456;
            CRV_OVL: b = -16'sd4096;
            default: b = 16'sd10240;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pot_a_code(input logic [1:0] r);
        logic [7:0] c;
        unique case (r)
            RNG_HI:  c = 8'd0;
            RNG_MID: c = 8'd7;
            default: c = 8'd26;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pot_b_code(input logic [1:0] r);
        logic [7:0] c;
        unique case (r)
            RNG_HI:  c = 8'd0;
            RNG_MID: c = 8'd17;
            default: c = 8'd97;
        endcase
        return c;
    endfunction

endpackage

### rtl/aslm_range_ctl.sv
// Gain range register and window decision for each incoming sample.
module aslm_range_ctl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [aslm_pkg::SAMPLE_BITS-1:0] i_sample,
    output aslm_pkg::t_side                 o_side
);
    import aslm_pkg::*;

    logic [1:0] r_range;
    logic [1:0] n_range;
    logic [1:0] w_cur;
    t_side      w_side;

    // Decide reading or range step against the current window
    always_comb begin
        w_side       = '0;
        w_side.curve = CRV_R0;
        unique case (r_range)
            RNG_HI: begin
                w_cur = RNG_HI;
                if (i_sample <= R0_HI) begin
                    n_range = RNG_HI;
                    w_side.rd = 1'b1;
                end else begin
                    n_range = RNG_MID;
                end
            end
            RNG_MID: begin
                w_cur = RNG_MID;
                if (i_sample < R1_LO) begin
                    n_range = RNG_HI;
                end else if (i_sample > R1_HI) begin
                    n_range = RNG_LO;
                end else begin
                    n_range      = RNG_MID;
                    w_side.rd    = 1'b1;
                    w_side.curve = CRV_R1;
                end
            end
            default: begin
                w_cur = RNG_LO;
                if (i_sample < R2_LO) begin
                    n_range = RNG_MID;
                end else if (i_sample > R2_HI) begin
                    n_range      = RNG_LO;
                    w_side.rd    = 1'b1;
                    w_side.ovl   = 1'b1;
                    w_side.curve = CRV_OVL;
                end else begin
                    n_range      = RNG_LO;
                    w_side.rd    = 1'b1;
                    w_side.curve = CRV_R2;
                end
            end
        endcase
        w_side.rng = n_range;
        w_side.chg = (n_range != w_cur);
    end

    // Advance the range on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RNG_HI;
        end else if (i_accept) begin
            r_range <= n_range;
        end
    end

    assign o_side = w_side;

endmodule

### rtl/aslm_sq_stage.sv
// One registered squaring step of the log2 fraction pipeline.
module aslm_sq_stage (
    input  logic           i_clk,
    input  logic           i_en,
    input  aslm_pkg::t_lgw i_lgw,
    output aslm_pkg::t_lgw o_lgw
);
    import aslm_pkg::*;

    logic [2*Y_BITS-1:0] w_sq;
    logic [Y_BITS:0]     w_top;
    t_lgw                n_lgw;
    t_lgw                r_lgw;

    // Square the mantissa; renormalize and emit one fraction bit
    always_comb begin
        w_sq       = i_lgw.y * i_lgw.y;
        w_top      = w_sq[2*Y_BITS-1:FRAC_BITS];
        n_lgw.n    = i_lgw.n;
        n_lgw.frac = {i_lgw.frac[FRAC_BITS-2:0], w_top[Y_BITS]};
        n_lgw.y    = w_top[Y_BITS] ? w_top[Y_BITS:1] : w_top[Y_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lgw <= n_lgw;
        end
    end

    assign o_lgw = r_lgw;

endmodule

### rtl/aslm_level.sv
// Log10 scaling, slope multiply, rounding and saturation to the Q8.8 level.
module aslm_level (
    input  logic                                  i_clk,
    input  logic                                  i_en_lg,
    input  logic                                  i_en_mul,
    input  logic                                  i_en_out,
    input  aslm_pkg::t_lgw                        i_lgw,
    input  logic signed [aslm_pkg::OFS_BITS-1:0]  i_ofs,
    input  aslm_pkg::t_curve                      i_curve_mul,
    input  aslm_pkg::t_curve                      i_curve_out,
    input  logic                                  i_rd_out,
    output logic signed [aslm_pkg::LVL_BITS-1:0]  o_level
);
    import aslm_pkg::*;

    logic [L2_BITS-1:0]           w_l2;
    logic [PROD_BITS-1:0]         w_prod;
    logic [LG_BITS-1:0]           n_lg;
    logic [LG_BITS-1:0]           r_lg;
    logic signed [T_BITS-1:0]     w_t;
    logic signed [V_BITS-1:0]     n_v;
    logic signed [V_BITS-1:0]     r_v;
    logic signed [V_BITS-1:0]     w_vr;
    logic signed [SUM_BITS-1:0]   w_sum;
    logic signed [LVL_BITS-1:0]   n_level;
    logic signed [LVL_BITS-1:0]   r_level;

    // Scale log2 by log10(2) and round to Q4.12
    always_comb begin
        w_l2   = {i_lgw.n, i_lgw.frac};
        w_prod = PROD_BITS'(w_l2) * PROD_BITS'(LOG10_2_Q16) + LG_RND;
        n_lg   = LG_BITS'(w_prod >> LG_SHIFT);
    end

    // Add the scale offset and apply the curve slope
    always_comb begin
        w_t = signed'(T_BITS'(r_lg)) + T_BITS'(i_ofs);
        n_v = V_BITS'(w_t) * V_BITS'(curve_slope(i_curve_mul));
    end

    // Round half up to Q8.8, add the range offset, saturate; zero when not a reading
    always_comb begin
        w_vr  = r_v + V_BITS'(8);
        w_sum = SUM_BITS'(w_vr >>> 4) + SUM_BITS'(curve_base(i_curve_out));
        if (!i_rd_out) begin
            n_level = '0;
        end else if (w_sum > SUM_BITS'(32767)) begin
            n_level = 16'sh7FFF;
        end else if (w_sum < -SUM_BITS'(32768)) begin
            n_level = -16'sh8000;
        end else begin
            n_level = LVL_BITS'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_lg) begin
            r_lg <= n_lg;
        end
        if (i_en_mul) begin
            r_v <= n_v;
        end
        if (i_en_out) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

### rtl/autorange_sound_level_meter_core.sv
// Autoranging sound level meter: one pipelined sample-to-level path with range control.
// Takes one envelope sample per cycle while o_s_tready is high and returns one result
// per sample, in order. The gain range is updated the cycle a sample is accepted, so
// back-to-back samples always see the range left by the one before. The level travels
// through a 20-stage pipeline (input normalize, 16 squaring stages that each produce one
// bit of the log2 fraction, log10 scaling, slope multiply, rounding and saturation).
// A sustained rate of one result per cycle holds unless the output stalls. Empty stages
// close up while the output is stalled, so samples keep being accepted until all 20
// stages are full. The offset register must be written only while the pipeline is empty.
module autorange_sound_level_meter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample request
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [aslm_pkg::S_TDATA_BITS-1:0] i_s_tdata,  // [SAMPLE_BITS-1:0] sample, rest 0
    // result request
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [39:0]                       o_m_tdata,  // level_db[15:0], range_now[17:16],
                                                          // pot_a_code[25:18],
                                                          // pot_b_code[33:26], rest 0
    output logic [2:0]                        o_m_tuser,  // level_valid[0], overload[1],
                                                          // gain_changed[2]
    // offset register
    input  logic                              i_cfg_wen,
    input  logic [15:0]                       i_cfg_wdata
);
    import aslm_pkg::*;

    logic signed [OFS_BITS-1:0] r_log_ofs;
    logic [DEPTH-1:0]           r_vld;
    logic [DEPTH-1:0]           w_space;
    logic [DEPTH-1:0]           w_load;
    t_side                      r_side [DEPTH];
    t_side                      w_side_in;
    t_lgw                       r_lg0;
    t_lgw                       n_lg0;
    t_lgw                       w_lgw [SQ_STAGES+1];
    logic [SAMPLE_BITS-1:0]     w_sample;
    logic [X_BITS-1:0]          w_x;
    logic [N_BITS-1:0]          w_n;
    logic [SH_BITS-1:0]         w_sh;
    logic signed [LVL_BITS-1:0] w_level;
    t_side                      w_out;

    assign w_sample = i_s_tdata[SAMPLE_BITS-1:0];

    // Hold the scale offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_ofs <= LOG_OFS_RST;
        end else if (i_cfg_wen) begin
            r_log_ofs <= signed'(i_cfg_wdata);
        end
    end

    // Stage k has room when it or any later stage is empty, or the output drains
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_ctl
            assign w_space[k] = i_m_tready | ~(&r_vld[LAST:k]);
            if (k == 0) begin : g_first
                assign w_load[k] = i_s_tvalid & w_space[k];
            end else begin : g_next
                assign w_load[k] = r_vld[k-1] & w_space[k];
            end
        end
    endgenerate

    assign o_s_tready = w_space[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= w_load | (r_vld & ~w_space);
        end
    end

    // Range decision for the incoming sample
    aslm_range_ctl u_rng (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_load[0]),
        .i_sample (w_sample),
        .o_side   (w_side_in)
    );

    // Advance the sideband beside the data stages
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (w_load[i]) begin
                r_side[i] <= (i == 0) ? w_side_in : r_side[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // Normalize sample + 1 to a Q1.16 mantissa and its leading-one index
    always_comb begin
        w_x = X_BITS'(w_sample) + X_BITS'(1);
        w_n = '0;
        for (int i = 0; i < X_BITS; i++) begin
            if (w_x[i]) begin
                w_n = N_BITS'(i);
            end
        end
        w_sh       = SH_BITS'(FRAC_BITS) - SH_BITS'(w_n);
        n_lg0.y    = Y_BITS'(w_x) << w_sh;
        n_lg0.frac = '0;
        n_lg0.n    = w_n;
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_lg0 <= n_lg0;
        end
    end

    assign w_lgw[0] = r_lg0;

    // One fraction bit per stage
    generate
        for (k = 0; k < SQ_STAGES; k++) begin : g_sq
            aslm_sq_stage u_sq (
                .i_clk (i_clk),
                .i_en  (w_load[k+1]),
                .i_lgw (w_lgw[k]),
                .o_lgw (w_lgw[k+1])
            );
        end
    endgenerate

    // Scale, round and saturate the level
    aslm_level u_lvl (
        .i_clk       (i_clk),
        .i_en_lg     (w_load[SQ_STAGES+1]),
        .i_en_mul    (w_load[SQ_STAGES+2]),
        .i_en_out    (w_load[LAST]),
        .i_lgw       (w_lgw[SQ_STAGES]),
        .i_ofs       (r_log_ofs),
        .i_curve_mul (r_side[SQ_STAGES+1].curve),
        .i_curve_out (r_side[SQ_STAGES+2].curve),
        .i_rd_out    (r_side[SQ_STAGES+2].rd),
        .o_level     (w_level)
    );

    // Drive the result request
    assign w_out      = r_side[LAST];
    assign o_m_tvalid = r_vld[LAST];
    assign o_m_tdata  = {6'd0, pot_b_code(w_out.rng), pot_a_code(w_out.rng), w_out.rng,
                         w_level};
    assign o_m_tuser  = {w_out.chg, w_out.ovl, w_out.rd};

endmodule
